>>> rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// Free list allocator package
// Shared widths and constants of the first-fit free list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned HeapUnits = 4096;
  localparam int unsigned UnitBytes = 16;
  localparam int unsigned AddrW     = $clog2(HeapUnits);
  localparam int unsigned UnitShift = $clog2(UnitBytes);
  localparam int unsigned BytesW    = 16;
  localparam int unsigned NeedW     = BytesW - UnitShift + 2;
  localparam int unsigned CountW    = AddrW + 1;

  localparam logic [CountW-1:0] ScanLimit = CountW'(HeapUnits);
  localparam logic [AddrW-1:0]  WholeHeap = AddrW'(HeapUnits - 1);

  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  localparam logic StatDone = 1'b0;
  localparam logic StatOom  = 1'b1;

endpackage

>>> rtl/ffa_if.sv
// ----------------------------------------------------------------------------
// Free list allocator channels
// Request and response valid/ready channels.
// ----------------------------------------------------------------------------
interface ffa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [ffa_pkg::BytesW-1:0]    request_bytes;
  logic [ffa_pkg::AddrW-1:0]     block_address;

  modport source (output valid, action, request_bytes, block_address, input ready);
  modport sink (input valid, action, request_bytes, block_address, output ready);
endinterface

interface ffa_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [ffa_pkg::AddrW-1:0] user_address;
  logic                      status;

  modport source (output valid, user_address, status, input ready);
  modport sink (input valid, user_address, status, output ready);
endinterface

>>> rtl/ffa_ram.sv
// ----------------------------------------------------------------------------
// Free list allocator RAM
// Simple dual port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int unsigned DataW = 12,
  parameter int unsigned AddrW = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/first_fit_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// First-fit free list allocator core
// An allocate answers from state A2 on an exact fit and from A3 when it
// splits a block, after walking up to 4096 further links.
// A free answers from state F6, or from F1 when it finds no place, after
// walking up to 4096 further links; a free of the sentinel answers from idle.
// One request is in work at a time; the response sits in its own register.
// After reset a clearing pass over all 4096 units builds the initial heap.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  ffa_req_if.sink  req,
  ffa_rsp_if.source rsp
);

  localparam int unsigned AW = ffa_pkg::AddrW;
  localparam int unsigned CW = ffa_pkg::CountW;
  localparam int unsigned NW = ffa_pkg::NeedW;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_A1   = 4'd2;
  localparam logic [3:0] S_A2   = 4'd3;
  localparam logic [3:0] S_A3   = 4'd4;
  localparam logic [3:0] S_F1   = 4'd5;
  localparam logic [3:0] S_F2   = 4'd6;
  localparam logic [3:0] S_F3   = 4'd7;
  localparam logic [3:0] S_F4   = 4'd8;
  localparam logic [3:0] S_F5   = 4'd9;
  localparam logic [3:0] S_F6   = 4'd10;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] rover_q, rover_d;
  logic [AW-1:0] prev_q, prev_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] hdr_q, hdr_d;
  logic [NW-1:0] need_q, need_d;
  logic [AW-1:0] buh_q, buh_d;
  logic [AW-1:0] nlh_q, nlh_d;
  logic [AW-1:0] bunx_q, bunx_d;
  logic          rvalid_q, rvalid_d;
  logic [AW-1:0] raddr_q, raddr_d;
  logic          rstat_q, rstat_d;

  logic          nl_we, bu_we;
  logic [AW-1:0] nl_waddr, nl_wdata, nl_raddr, nl_rdata;
  logic [AW-1:0] bu_waddr, bu_wdata, bu_raddr, bu_rdata;

  logic [NW-1:0]   round_up;
  logic [AW-1:0]   remain;
  logic [AW-1:0]   carve;
  logic [AW:0]     hdr_end;
  logic [AW:0]     p_end;
  logic            req_fire;

  ffa_ram #(.DataW(AW), .AddrW(AW)) u_next_link (
    .clk_i, .we_i(nl_we), .waddr_i(nl_waddr), .wdata_i(nl_wdata),
    .raddr_i(nl_raddr), .rdata_o(nl_rdata)
  );

  ffa_ram #(.DataW(AW), .AddrW(AW)) u_block_units (
    .clk_i, .we_i(bu_we), .waddr_i(bu_waddr), .wdata_i(bu_wdata),
    .raddr_i(bu_raddr), .rdata_o(bu_rdata)
  );

  assign req.ready        = (state_q == S_IDLE) && !rvalid_q;
  assign req_fire         = req.valid && req.ready;
  assign rsp.valid        = rvalid_q;
  assign rsp.user_address = raddr_q;
  assign rsp.status       = rstat_q;

  always_comb begin
    logic [ffa_pkg::BytesW-1:0] bytes;
    logic [ffa_pkg::BytesW:0]   sum;
    bytes    = (req.request_bytes == '0) ? ffa_pkg::BytesW'(1) : req.request_bytes;
    sum      = {1'b0, bytes} + (ffa_pkg::BytesW + 1)'(ffa_pkg::UnitBytes - 1);
    round_up = NW'(sum >> ffa_pkg::UnitShift) + NW'(1);
  end

  assign remain  = bu_rdata - AW'(need_q);
  assign carve   = cur_q + remain;
  assign hdr_end = {1'b0, hdr_q} + {1'b0, buh_q};
  assign p_end   = {1'b0, prev_q} + {1'b0, bu_rdata};

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rover_d  = rover_q;
    prev_d   = prev_q;
    cur_d    = cur_q;
    hdr_d    = hdr_q;
    need_d   = need_q;
    buh_d    = buh_q;
    nlh_d    = nlh_q;
    bunx_d   = bunx_q;
    rvalid_d = rvalid_q;
    raddr_d  = raddr_q;
    rstat_d  = rstat_q;
    nl_we    = 1'b0;
    bu_we    = 1'b0;
    nl_waddr = '0;
    nl_wdata = '0;
    bu_waddr = '0;
    bu_wdata = '0;
    nl_raddr = '0;
    bu_raddr = '0;

    if (rvalid_q && rsp.ready) begin
      rvalid_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        nl_we    = 1'b1;
        bu_we    = 1'b1;
        nl_waddr = cnt_q[AW-1:0];
        bu_waddr = cnt_q[AW-1:0];
        nl_wdata = (cnt_q[AW-1:0] == AW'(0)) ? AW'(1) : '0;
        bu_wdata = (cnt_q[AW-1:0] == AW'(1)) ? ffa_pkg::WholeHeap : '0;
        cnt_d    = cnt_q + CW'(1);
        if (cnt_q[AW-1:0] == ffa_pkg::WholeHeap) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        nl_raddr = rover_q;
        prev_d   = rover_q;
        need_d   = round_up;
        hdr_d    = req.block_address - AW'(1);
        cnt_d    = '0;
        if (req_fire) begin
          if (req.action == ffa_pkg::ActAlloc) begin
            state_d = S_A1;
          end else if (req.block_address < AW'(2)) begin
            rvalid_d = 1'b1;
            raddr_d  = '0;
            rstat_d  = ffa_pkg::StatDone;
          end else begin
            state_d = S_F1;
          end
        end
      end
      S_A1: begin
        cur_d    = nl_rdata;
        nl_raddr = nl_rdata;
        bu_raddr = nl_rdata;
        state_d  = S_A2;
      end
      S_A2: begin
        if (NW'(bu_rdata) >= need_q) begin
          rover_d = prev_q;
          rstat_d = ffa_pkg::StatDone;
          if (NW'(bu_rdata) == need_q) begin
            nl_we    = 1'b1;
            nl_waddr = prev_q;
            nl_wdata = nl_rdata;
            raddr_d  = cur_q + AW'(1);
            rvalid_d = 1'b1;
            state_d  = S_IDLE;
          end else begin
            bu_we    = 1'b1;
            bu_waddr = cur_q;
            bu_wdata = remain;
            cur_d    = carve;
            raddr_d  = carve + AW'(1);
            state_d  = S_A3;
          end
        end else if (cur_q == rover_q || cnt_q == ffa_pkg::ScanLimit) begin
          raddr_d  = '0;
          rstat_d  = ffa_pkg::StatOom;
          rvalid_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          prev_d   = cur_q;
          cur_d    = nl_rdata;
          nl_raddr = nl_rdata;
          bu_raddr = nl_rdata;
          cnt_d    = cnt_q + CW'(1);
        end
      end
      S_A3: begin
        bu_we    = 1'b1;
        bu_waddr = cur_q;
        bu_wdata = AW'(need_q);
        rvalid_d = 1'b1;
        state_d  = S_IDLE;
      end
      S_F1: begin
        cur_d = nl_rdata;
        if ((hdr_q > prev_q && hdr_q < nl_rdata) ||
            (prev_q >= nl_rdata && (hdr_q > prev_q || hdr_q < nl_rdata))) begin
          nl_raddr = nl_rdata;
          bu_raddr = hdr_q;
          state_d  = S_F2;
        end else if (cnt_q == ffa_pkg::ScanLimit) begin
          raddr_d  = '0;
          rstat_d  = ffa_pkg::StatDone;
          rvalid_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          prev_d   = nl_rdata;
          nl_raddr = nl_rdata;
          cnt_d    = cnt_q + CW'(1);
        end
      end
      S_F2: begin
        buh_d    = bu_rdata;
        nlh_d    = nl_rdata;
        bu_raddr = cur_q;
        state_d  = S_F3;
      end
      S_F3: begin
        bunx_d   = bu_rdata;
        bu_raddr = prev_q;
        state_d  = S_F4;
      end
      S_F4: begin
        bu_raddr = prev_q;
        nl_we    = 1'b1;
        nl_waddr = hdr_q;
        if (hdr_end == {1'b0, cur_q}) begin
          bu_we    = 1'b1;
          bu_waddr = hdr_q;
          bu_wdata = buh_q + bunx_q;
          buh_d    = buh_q + bunx_q;
          nl_wdata = nlh_q;
        end else begin
          nl_wdata = cur_q;
          nlh_d    = cur_q;
        end
        state_d = S_F5;
      end
      S_F5: begin
        nl_we    = 1'b1;
        nl_waddr = prev_q;
        if (p_end == {1'b0, hdr_q}) begin
          bu_we    = 1'b1;
          bu_waddr = prev_q;
          bu_wdata = bu_rdata + buh_q;
          nl_wdata = nlh_q;
        end else begin
          nl_wdata = hdr_q;
        end
        rover_d = prev_q;
        state_d = S_F6;
      end
      S_F6: begin
        raddr_d  = '0;
        rstat_d  = ffa_pkg::StatDone;
        rvalid_d = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      cnt_q    <= '0;
      rover_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rover_q  <= rover_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q  <= prev_d;
    cur_q   <= cur_d;
    hdr_q   <= hdr_d;
    need_q  <= need_d;
    buh_q   <= buh_d;
    nlh_q   <= nlh_d;
    bunx_q  <= bunx_d;
    raddr_q <= raddr_d;
    rstat_q <= rstat_d;
  end

  // A new request is never taken while one is in work.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while busy");

  // An out-of-memory answer never carries an address.
  a_oom_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.status |-> rsp.user_address == '0)
    else $error("out-of-memory response with address");

  // No request is taken during the clearing pass.
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |-> !req.ready)
    else $error("request taken during clearing pass");

endmodule
